/* design/rthsc_pkg.sv */
// ----------------------------------------------------------------------------
// rthsc_pkg
// Shared types and fixed constants of the rate to hue step curve.
// ----------------------------------------------------------------------------
package rthsc_pkg;

  localparam int RATE_W   = 20;
  localparam int TICK_W   = 10;
  localparam int PERIOD_W = 15;
  localparam int STEP_W   = 17;

  typedef logic [RATE_W-1:0]   rate_t;
  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [STEP_W-1:0]   step_t;

  localparam tick_t TICK_RESET = tick_t'(20);

  // breakpoints (rate, period)
  localparam rate_t   BP_RATE_1   = rate_t'(4000);
  localparam rate_t   BP_RATE_2   = rate_t'(16000);
  localparam rate_t   BP_RATE_3   = rate_t'(40000);
  localparam period_t BP_PERIOD_0 = period_t'(20000);
  localparam period_t BP_PERIOD_1 = period_t'(8000);
  localparam period_t BP_PERIOD_2 = period_t'(2000);
  localparam period_t BP_PERIOD_3 = period_t'(750);

  // ceil(2^17 / 3), exact floor(y / 3) for y below 2^16
  localparam logic [15:0] RECIP3       = 16'd43691;
  localparam int          RECIP3_SHIFT = 17;

  // smallest period is above 2^9, so the top bits of the dividend never divide
  localparam int DIV_SKIP_W = 9;

endpackage

/* design/rthsc_if.sv */
// ----------------------------------------------------------------------------
// rthsc channel interfaces
// Valid/ready channels for rate input, result output and tick configuration.
// ----------------------------------------------------------------------------
interface rthsc_in_if
  import rthsc_pkg::*;
();
  logic  valid;
  logic  ready;
  rate_t activity_rate;

  modport source (output valid, output activity_rate, input ready);
  modport sink   (input valid, input activity_rate, output ready);
endinterface

interface rthsc_out_if
  import rthsc_pkg::*;
();
  logic    valid;
  logic    ready;
  period_t rotation_period;
  step_t   hue_step;

  modport source (output valid, output rotation_period, output hue_step, input ready);
  modport sink   (input valid, input rotation_period, input hue_step, output ready);
endinterface

interface rthsc_cfg_if
  import rthsc_pkg::*;
();
  logic  valid;
  logic  ready;
  tick_t tick_length_ms;

  modport source (output valid, output tick_length_ms, input ready);
  modport sink   (input valid, input tick_length_ms, output ready);
endinterface

/* design/rate_to_hue_step_curve.sv */
// ----------------------------------------------------------------------------
// rate_to_hue_step_curve
// Activity rate to rotation period and per-tick hue step.
// ----------------------------------------------------------------------------
// Takes one rate transaction per cycle unless the output stalls, and returns
// one result per rate, in order. A registered head cell does the breakpoint
// interpolation, then a row of division cells, one quotient bit each, forms
// the hue step (QW = 18 quotient bits at the default full turn of 65536).
// The whole row advances together whenever the output is empty or taken, so
// a result that waits at the output holds the whole row and blocks intake at
// once. tick_length_ms resets to 20 and is written through the cfg channel,
// which is always ready; write it only while no transaction is in flight.
module rate_to_hue_step_curve
  import rthsc_pkg::*;
#(
  parameter int HUE_FULL_TURN = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  rthsc_in_if.sink    in_ch,
  rthsc_out_if.source out_ch,
  rthsc_cfg_if.sink   cfg_ch
);

  localparam int HUE_W = $clog2(HUE_FULL_TURN + 1);
  localparam int DVD_W = HUE_W + TICK_W;
  localparam int QW    = DVD_W - DIV_SKIP_W;

  tick_t tick_r;
  logic  en;

  logic             v   [0:QW];
  period_t          per [0:QW];
  logic [DVD_W-1:0] dvd [0:QW];
  period_t          rem [0:QW];
  logic [QW-1:0]    quo [0:QW];

  logic [QW+STEP_W-1:0] step_ext;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_RESET;
    end else if (cfg_ch.valid) begin
      tick_r <= cfg_ch.tick_length_ms;
    end
  end

  // whole row shifts when the last cell is empty or being drained
  assign en          = !v[QW] || out_ch.ready;
  assign in_ch.ready = en;

  rthsc_interp #(
    .HUE_FULL_TURN (HUE_FULL_TURN),
    .DVD_W         (DVD_W)
  ) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .rate     (in_ch.activity_rate),
    .tick     (tick_r),
    .valid_r  (v[0]),
    .period_r (per[0]),
    .dvd_r    (dvd[0])
  );

  assign rem[0] = PERIOD_W'(dvd[0][DVD_W-1 -: DIV_SKIP_W]);
  assign quo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    rthsc_div_cell #(
      .DVD_W (DVD_W),
      .QW    (QW),
      .BIT   (QW - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid    (v[k]),
      .period   (per[k]),
      .dvd      (dvd[k]),
      .rem      (rem[k]),
      .quo      (quo[k]),
      .valid_r  (v[k+1]),
      .period_r (per[k+1]),
      .dvd_r    (dvd[k+1]),
      .rem_r    (rem[k+1]),
      .quo_r    (quo[k+1])
    );
  end

  assign step_ext               = {{STEP_W{1'b0}}, quo[QW]};
  assign out_ch.valid           = v[QW];
  assign out_ch.rotation_period = per[QW];
  assign out_ch.hue_step        = step_ext[STEP_W-1:0];

endmodule

/* design/rthsc_interp.sv */
// ----------------------------------------------------------------------------
// rthsc_interp
// Head cell: piecewise-linear rate to period mapping and hue dividend.
// ----------------------------------------------------------------------------
module rthsc_interp
  import rthsc_pkg::*;
#(
  parameter int HUE_FULL_TURN = 65536,
  parameter int DVD_W         = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  rate_t            rate,
  input  tick_t            tick,
  output logic             valid_r,
  output period_t          period_r,
  output logic [DVD_W-1:0] dvd_r
);

  logic [14:0] off3;
  logic [16:0] x5;
  logic [11:0] y;
  logic [27:0] yq;
  logic [14:0] off2;
  logic [11:0] off1;
  logic [13:0] mul3;
  period_t     period_nxt;
  logic [DVD_W-1:0] dvd_nxt;

  always_comb begin
    off3 = 15'(rate - BP_RATE_2);
    x5   = {2'b00, off3} + {off3, 2'b00};
    y    = x5[16:5];
    yq   = 28'(y) * 28'(RECIP3);
    off2 = 15'(rate - BP_RATE_1);
    off1 = rate[11:0];
    mul3 = {2'b00, off1} + {1'b0, off1, 1'b0};
    if (rate >= BP_RATE_3) begin
      period_nxt = BP_PERIOD_3;
    end else if (rate >= BP_RATE_2) begin
      period_nxt = BP_PERIOD_2 - period_t'(yq[27:RECIP3_SHIFT]);
    end else if (rate >= BP_RATE_1) begin
      period_nxt = BP_PERIOD_1 - period_t'(off2[14:1]);
    end else begin
      period_nxt = BP_PERIOD_0 - period_t'(mul3);
    end
    dvd_nxt = DVD_W'(HUE_FULL_TURN) * DVD_W'(tick);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      period_r <= period_nxt;
      dvd_r    <= dvd_nxt;
    end
  end

endmodule

/* design/rthsc_div_cell.sv */
// ----------------------------------------------------------------------------
// rthsc_div_cell
// One restoring division step: resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
module rthsc_div_cell
  import rthsc_pkg::*;
#(
  parameter int DVD_W = 27,
  parameter int QW    = 18,
  parameter int BIT   = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid,
  input  period_t          period,
  input  logic [DVD_W-1:0] dvd,
  input  period_t          rem,
  input  logic [QW-1:0]    quo,
  output logic             valid_r,
  output period_t          period_r,
  output logic [DVD_W-1:0] dvd_r,
  output period_t          rem_r,
  output logic [QW-1:0]    quo_r
);

  logic [PERIOD_W:0] trial;
  logic [PERIOD_W:0] diff;
  logic              ge;
  period_t           rem_nxt;
  logic [QW-1:0]     quo_nxt;

  always_comb begin
    trial   = {rem, dvd[BIT]};
    diff    = trial - {1'b0, period};
    ge      = (trial >= {1'b0, period});
    rem_nxt = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    quo_nxt = quo;
    quo_nxt[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      period_r <= period;
      dvd_r    <= dvd;
      rem_r    <= rem_nxt;
      quo_r    <= quo_nxt;
    end
  end

endmodule
